// ===== hw/rtl/imufir_pkg.sv =====
package imufir_pkg;

    // Sensor kind codes carried in tuser
    localparam logic [1:0] KIND_GYRO   = 2'd0;
    localparam logic [1:0] KIND_ACCEL  = 2'd1;
    localparam logic [1:0] KIND_ORIENT = 2'd2;
    localparam logic [1:0] KIND_FLEX   = 2'd3;

    localparam logic [11:0] FLEX_THRESHOLD_RESET = 12'd1700;

    // Symmetric low-pass tables: first half plus center tap, one row per filtered kind (gyro, accel, orientation)
    localparam int TABLE_TAPS = 101;
    localparam int HALF_TAPS  = 51;

    localparam shortint COEF_TABLE [3][HALF_TAPS] = '{
        '{ -15, -10, 0, 11, 20, 23, 19, 6, -13, -32,
           -44, -41, -21, 12, 51, 79, 83, 56, 0, -69,
           -128, -150, -120, -36, 78, 187, 247, 225, 114, -63,
           -252, -382, -394, -260, 0, 313, 573, 673, 538, 165,
           -364, -894, -1229, -1184, -644, 398, 1817, 3382, 4800, 5789,
           6143 },
        '{ 3, 13, 18, 15, 4, -11, -25, -29, -19, 4,
           31, 49, 47, 18, -27, -71, -88, -64, 0, 79,
           135, 135, 65, -54, -170, -224, -175, -27, 165, 311,
           328, 183, -83, -361, -512, -435, -121, 323, 702, 810,
           528, -105, -868, -1416, -1397, -591, 982, 3037, 5089, 6602,
           7158 },
        '{ 12, 7, 0, -7, -15, -22, -27, -28, -24, -15,
           0, 19, 40, 59, 72, 74, 64, 39, 0, -48,
           -98, -142, -169, -172, -145, -86, 0, 104, 210, 301,
           356, 360, 302, 179, 0, -216, -439, -634, -762, -785,
           -674, -412, 0, 546, 1191, 1886, 2573, 3190, 3679, 3993,
           4101 }
    };

    // Coefficient of one tap; taps past the table are zero
    function automatic logic signed [15:0] coef_at(input logic [1:0] kind,
                                                   input int unsigned tap);
        logic [5:0]         j;
        logic signed [15:0] c;
        c = '0;
        j = '0;
        if (tap < TABLE_TAPS && kind != KIND_FLEX) begin
            j = (tap < HALF_TAPS) ? 6'(tap) : 6'(TABLE_TAPS - 1 - tap);
            c = COEF_TABLE[kind][j];
        end
        return c;
    endfunction

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Sequencer to lane controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_clr;
    } lane_ctrl_t;

    // Lane pipeline occupancy
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } lane_stat_t;

endpackage

// ===== hw/rtl/imufir_ram.sv =====
module imufir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 303,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/imufir_lane.sv =====
module imufir_lane #(
    parameter int TAPS         = 101,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 16,
    localparam int AW = $clog2(3 * TAPS),
    localparam int PW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  imufir_pkg::lane_ctrl_t         ctrl,
    input  logic [AW-1:0]                  addr,
    input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
    input  logic [PW-1:0]                  tap_idx,
    input  logic [1:0]                     kind,
    output imufir_pkg::lane_stat_t         stat,
    output logic signed [SAMPLE_WIDTH-1:0] filtered
);
    import imufir_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + 16;
    localparam int ACC_W  = PROD_W + $clog2(TAPS + 1) + 1;
    localparam int FRAC   = COEFF_WIDTH - 1;
    localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [ACC_W:0] SAT_HI =
        (ACC_W + 1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W + 1)'(1);

    logic [SAMPLE_WIDTH-1:0]  rd_data;
    logic                     s1_valid_reg;
    logic [PW-1:0]            s1_tap_reg;
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [15:0]       coef;
    logic signed [ACC_W:0]    rounded;
    logic signed [ACC_W:0]    shifted;

    // Sample history, three kinds side by side
    imufir_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (3 * TAPS)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Stage 1: history word meets its coefficient
    assign coef      = coef_at(kind, 32'(s1_tap_reg));
    assign prod_next = $signed(rd_data) * coef;

    // Stage 2: accumulate
    assign acc_next = acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= ctrl.rd_en;
            s2_valid_reg <= s1_valid_reg;
        end
        s1_tap_reg <= tap_idx;
        if (s1_valid_reg) begin
            prod_reg <= prod_next;
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (s2_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Round half up, then saturate
    always_comb begin
        rounded = (ACC_W + 1)'(acc_reg) + HALF;
        shifted = rounded >>> FRAC;
        if (shifted > SAT_HI) begin
            filtered = SAMPLE_WIDTH'(SAT_HI);
        end else if (shifted < SAT_LO) begin
            filtered = SAMPLE_WIDTH'(SAT_LO);
        end else begin
            filtered = SAMPLE_WIDTH'(shifted);
        end
    end

    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;

    // A product only reaches the adder after its read has passed through stage 1
    a_prod_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("lane product without a preceding read");

endmodule

// ===== hw/rtl/imufir_merge.sv =====
module imufir_merge #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int M_DW = ((6 * SAMPLE_WIDTH + 6 + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [1:0]                     kind,
    input  logic signed [SAMPLE_WIDTH-1:0] filt [3],
    input  logic [11:0]                    flex [3],
    input  logic [11:0]                    threshold,
    output logic                           out_free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_DW-1:0]                m_tdata,
    output logic [1:0]                     m_tuser
);
    import imufir_pkg::*;

    logic                           m_tvalid_reg;
    logic [1:0]                     kind_reg;
    logic signed [SAMPLE_WIDTH-1:0] filt_reg  [3];
    logic signed [SAMPLE_WIDTH:0]   delta_reg [3];
    logic                           bent_reg  [3];
    logic signed [SAMPLE_WIDTH-1:0] last_reg  [3];
    logic signed [SAMPLE_WIDTH:0]   delta_next [3];
    logic                           is_orient;
    logic                           is_flex;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_orient = (kind == KIND_ORIENT);
    assign is_flex   = (kind == KIND_FLEX);

    // Change against the previous filtered orientation
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            delta_next[a] = {filt[a][SAMPLE_WIDTH-1], filt[a]}
                          - {last_reg[a][SAMPLE_WIDTH-1], last_reg[a]};
        end
    end

    // Output word register and orientation memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                last_reg[a] <= '0;
            end
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (load && is_orient) begin
                for (int a = 0; a < 3; a++) begin
                    last_reg[a] <= filt[a];
                end
            end
        end
        if (load) begin
            kind_reg <= kind;
            for (int a = 0; a < 3; a++) begin
                filt_reg[a]  <= is_flex ? '0 : filt[a];
                delta_reg[a] <= is_orient ? delta_next[a] : '0;
                bent_reg[a]  <= is_flex && (flex[a] <= threshold);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = M_DW'({bent_reg[2], bent_reg[1], bent_reg[0],
                             delta_reg[2], delta_reg[1], delta_reg[0],
                             filt_reg[2], filt_reg[1], filt_reg[0]});

    // Deltas only on orientation words
    a_delta_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && kind_reg != KIND_ORIENT
        |-> delta_reg[0] == '0 && delta_reg[1] == '0 && delta_reg[2] == '0)
        else $error("nonzero delta on a non-orientation word");

    // Orientation memory moves only with an orientation word
    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(load && is_orient)
        |=> $stable(last_reg[0]) && $stable(last_reg[1]) && $stable(last_reg[2]))
        else $error("last orientation changed without an orientation word");

endmodule

// ===== hw/rtl/imu_three_axis_fir_lowpass.sv =====
// Three-axis low-pass filter for an inertial sensor with flex bend flags.
// Each input word names a sensor kind in s_tuser (gyro, accel, orientation,
// flex). For the three sensor kinds, each axis sample goes into its own
// TAPS-deep history (one per kind and axis) and is filtered by that kind's
// symmetric Q1.15 low-pass FIR; results are rounded half up and saturated.
// Orientation words also carry each axis's change from the previous filtered
// orientation. Flex words carry bent flags (reading <= flex_threshold) and
// leave all histories untouched. Three lanes (x, y, z) each run one
// multiply-accumulate per tap from their own history RAM, one tap at a
// time through the single read port of each lane's history RAM, and a new
// word is accepted only once the previous word's pass has finished. A
// finished word waits in the output register while the next one is
// accepted. After reset the histories are zeroed by a sweep over all
// 3 * TAPS words of each history RAM, during which s_tready stays low;
// flex_threshold may be written at any time the block is idle.
module imu_three_axis_fir_lowpass #(
    parameter int TAPS         = 101,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 16,
    localparam int S_DW = ((3 * SAMPLE_WIDTH + 36 + 7) / 8) * 8,
    localparam int M_DW = ((6 * SAMPLE_WIDTH + 6 + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    // configuration: flex_threshold
    input  logic            cfg_wr_en,
    input  logic [11:0]     cfg_wr_data,
    // input words
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [S_DW-1:0] s_tdata,  // sample_x, sample_y, sample_z, flex_a, flex_b, flex_c
    input  logic [1:0]      s_tuser,  // kind
    // result words
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [M_DW-1:0] m_tdata,  // filtered_x/y/z, delta_x/y/z, bent_a/b/c
    output logic [1:0]      m_tuser   // kind
);
    import imufir_pkg::*;

    localparam int AW = $clog2(3 * TAPS);
    localparam int PW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SW = SAMPLE_WIDTH;
    localparam logic [AW-1:0] BASE_ACCEL  = AW'(TAPS);
    localparam logic [AW-1:0] BASE_ORIENT = AW'(2 * TAPS);
    localparam logic [AW-1:0] CLR_LAST    = AW'(3 * TAPS - 1);
    localparam logic [PW-1:0] TAP_LAST    = PW'(TAPS - 1);
    localparam logic [PW:0]   TAPS_EXT    = (PW + 1)'(TAPS);

    state_t state_reg, state_next;

    logic [11:0]           flex_threshold_reg;
    logic [1:0]            kind_reg;
    logic signed [SW-1:0]  sample_reg [3];
    logic [11:0]           flex_reg   [3];
    logic [AW-1:0]         clr_cnt_reg;
    logic [PW-1:0]         tap_cnt_reg;
    logic [PW-1:0]         wp_reg     [3];
    logic [PW-1:0]         wp_cur;
    logic [PW-1:0]         rd_idx;
    logic [AW-1:0]         base;
    logic [AW-1:0]         ram_addr;
    logic signed [SW-1:0]  lane_wdata [3];
    logic signed [SW-1:0]  lane_filt  [3];
    lane_ctrl_t            lane_ctrl;
    lane_stat_t            lane_stat  [3];
    logic                  lanes_busy;
    logic                  out_free;
    logic                  load;
    logic                  accept;

    assign accept = s_tvalid && s_tready;

    // Per-kind history window
    always_comb begin
        case (kind_reg)
            KIND_GYRO:   begin base = '0;          wp_cur = wp_reg[0]; end
            KIND_ACCEL:  begin base = BASE_ACCEL;  wp_cur = wp_reg[1]; end
            KIND_ORIENT: begin base = BASE_ORIENT; wp_cur = wp_reg[2]; end
            default:     begin base = '0;          wp_cur = '0;        end
        endcase
    end

    // Tap i sits i words behind the newest one, circularly
    assign rd_idx = (wp_cur >= tap_cnt_reg)
                  ? PW'(wp_cur - tap_cnt_reg)
                  : PW'((PW + 1)'(wp_cur) + TAPS_EXT - (PW + 1)'(tap_cnt_reg));

    assign lanes_busy = lane_stat[0].s1_valid || lane_stat[0].s2_valid
                     || lane_stat[1].s1_valid || lane_stat[1].s2_valid
                     || lane_stat[2].s1_valid || lane_stat[2].s2_valid;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == CLR_LAST) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == KIND_FLEX) ? ST_FINISH : ST_WRITE;
                end
            end
            ST_WRITE:  state_next = ST_RUN;
            ST_RUN:    if (tap_cnt_reg == TAP_LAST) state_next = ST_DRAIN;
            ST_DRAIN:  if (!lanes_busy) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready  = 1'b0;
        lane_ctrl = '0;
        ram_addr  = base + AW'(rd_idx);
        load      = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lane_wdata[a] = sample_reg[a];
        end
        case (state_reg)
            ST_CLEAR: begin
                lane_ctrl.wr_en = 1'b1;
                ram_addr        = clr_cnt_reg;
                for (int a = 0; a < 3; a++) begin
                    lane_wdata[a] = '0;
                end
            end
            ST_IDLE:   s_tready = 1'b1;
            ST_WRITE: begin
                lane_ctrl.wr_en   = 1'b1;
                lane_ctrl.acc_clr = 1'b1;
                ram_addr          = base + AW'(wp_cur);
            end
            ST_RUN:    lane_ctrl.rd_en = 1'b1;
            ST_FINISH: load = out_free;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLEAR;
            flex_threshold_reg <= FLEX_THRESHOLD_RESET;
            clr_cnt_reg        <= '0;
            tap_cnt_reg        <= '0;
            for (int a = 0; a < 3; a++) begin
                wp_reg[a] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                flex_threshold_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == ST_WRITE) begin
                tap_cnt_reg <= '0;
            end else if (state_reg == ST_RUN) begin
                tap_cnt_reg <= tap_cnt_reg + PW'(1);
            end
            // advance the kind's write pointer once the word is out
            if (load && kind_reg != KIND_FLEX) begin
                wp_reg[kind_reg] <= (wp_cur == TAP_LAST) ? '0 : wp_cur + PW'(1);
            end
        end
    end

    // Captured input word
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg      <= s_tuser;
            sample_reg[0] <= s_tdata[SW-1:0];
            sample_reg[1] <= s_tdata[2*SW-1:SW];
            sample_reg[2] <= s_tdata[3*SW-1:2*SW];
            flex_reg[0]   <= s_tdata[3*SW+11:3*SW];
            flex_reg[1]   <= s_tdata[3*SW+23:3*SW+12];
            flex_reg[2]   <= s_tdata[3*SW+35:3*SW+24];
        end
    end

    // One filter lane per axis
    for (genvar k = 0; k < 3; k++) begin : g_lane
        imufir_lane #(
            .TAPS         (TAPS),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COEFF_WIDTH  (COEFF_WIDTH)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .addr     (ram_addr),
            .wr_data  (lane_wdata[k]),
            .tap_idx  (tap_cnt_reg),
            .kind     (kind_reg),
            .stat     (lane_stat[k]),
            .filtered (lane_filt[k])
        );
    end

    imufir_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .kind      (kind_reg),
        .filt      (lane_filt),
        .flex      (flex_reg),
        .threshold (flex_threshold_reg),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // No lane work left over when a new word may enter
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !lanes_busy)
        else $error("lane pipeline busy while idle");

    // Write pointers stay inside their window
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg[0] <= TAP_LAST && wp_reg[1] <= TAP_LAST && wp_reg[2] <= TAP_LAST)
        else $error("history write pointer out of range");

    // An accepted word starts either the filter pass or a flex result
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_WRITE || state_reg == ST_FINISH)
        else $error("accepted word not started");

endmodule
